// File: src/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

    // Sequence phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WAIT_OFF = 3'd1;
    localparam logic [2:0] PH_WAIT_ON  = 3'd2;
    localparam logic [2:0] PH_STABLE1  = 3'd3;
    localparam logic [2:0] PH_STABLE2  = 3'd4;
    localparam logic [2:0] PH_STABLE3  = 3'd5;

    // Measurement commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Item kinds carried on tuser
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_MARGIN  = 1'b0;
    localparam logic CFG_RESTART = 1'b1;

    localparam logic [7:0] MARGIN_RESET  = 8'd10;
    localparam logic [7:0] RESTART_RESET = 8'd80;

    // field_cycles * 5000 / 223720 == (field_cycles * WAIT_MULT) >> WAIT_SHIFT
    // exactly for every 13-bit field_cycles.
    localparam logic [22:0] WAIT_MULT  = 23'd5999363;
    localparam int          WAIT_SHIFT = 28;

    localparam logic signed [17:0] REM_MIN = 18'sh20000;

    typedef struct packed {
        logic [7:0] margin_per_line;
        logic [7:0] restart_wait_ms;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] timeout_ms;
        logic        meas_enabled;
        logic        meas_interlaced;
        logic [4:0]  vsync_lines;
        logic [10:0] field_lines;
        logic [13:0] block_size;
        logic [12:0] field_cycles;
    } item_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] wait_ms;
        logic       done_res;
        logic       success;
    } res_t;

    function automatic logic [7:0] field_wait(input logic [12:0] cycles);
        logic [35:0] prod;
        prod = {23'd0, cycles} * {13'd0, WAIT_MULT};
        return prod[WAIT_SHIFT +: 8];
    endfunction

endpackage

// File: src/stc_cfg_regs.sv
`timescale 1ns / 1ps

module stc_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data,
    output logic          cfg_ready,
    output stc_pkg::cfg_t cfg
);
    import stc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.margin_per_line <= MARGIN_RESET;
            cfg_reg.restart_wait_ms <= RESTART_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MARGIN:  cfg_reg.margin_per_line <= cfg_data;
                CFG_RESTART: cfg_reg.restart_wait_ms <= cfg_data;
                default:     ;
            endcase
        end
    end

endmodule

// File: src/stc_seq.sv
`timescale 1ns / 1ps

module stc_seq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  stc_pkg::item_t item,
    input  stc_pkg::cfg_t  cfg,
    output stc_pkg::res_t  res
);
    import stc_pkg::*;

    logic [2:0]         phase_reg, phase_next;
    logic signed [17:0] rem_reg, rem_next;
    logic               ref_il_reg;
    logic [4:0]         ref_vs_reg;
    logic [10:0]        ref_fl_reg;
    logic [13:0]        ref_bs_reg;
    logic [12:0]        ref_fc_reg;

    logic [1:0]         cmd;
    logic [7:0]         wait_val;
    logic               done;
    logic               ok;
    logic               use_cons;
    logic               capture;
    logic               is_start;

    logic [7:0]         item_wait;
    logic [18:0]        fl_prod;
    logic [10:0]        fc_tol;
    logic [10:0]        bs_tol;
    logic [12:0]        fc_diff;
    logic [13:0]        bs_diff;
    logic               match;

    logic signed [17:0] rem_base;
    logic signed [18:0] rem_diff;
    logic signed [17:0] rem_cons;

    assign item_wait = field_wait(item.field_cycles);
    assign fl_prod   = {8'd0, ref_fl_reg} * {11'd0, cfg.margin_per_line};
    assign fc_tol    = fl_prod[18:8];
    assign bs_tol    = {cfg.margin_per_line, 3'b000};
    assign fc_diff   = (ref_fc_reg >= item.field_cycles) ? ref_fc_reg - item.field_cycles
                                                         : item.field_cycles - ref_fc_reg;
    assign bs_diff   = (ref_bs_reg >= item.block_size) ? ref_bs_reg - item.block_size
                                                       : item.block_size - ref_bs_reg;

    assign match = item.meas_enabled
                && (item.meas_interlaced == ref_il_reg)
                && (item.vsync_lines == ref_vs_reg)
                && (item.field_lines == ref_fl_reg)
                && (fc_diff <= {2'd0, fc_tol})
                && (bs_diff <= {3'd0, bs_tol});

    always_comb
    begin
        cmd        = CMD_NONE;
        wait_val   = 8'd0;
        done       = 1'b0;
        ok         = 1'b0;
        use_cons   = 1'b0;
        capture    = 1'b0;
        is_start   = 1'b0;
        phase_next = phase_reg;

        if (item.operation == OP_START)
        begin
            cmd        = CMD_STOP;
            wait_val   = 8'd1;
            phase_next = PH_WAIT_OFF;
            use_cons   = 1'b1;
            is_start   = 1'b1;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_WAIT_OFF:
                begin
                    if (!item.meas_enabled)
                    begin
                        cmd        = CMD_START;
                        wait_val   = cfg.restart_wait_ms;
                        phase_next = PH_WAIT_ON;
                        use_cons   = 1'b1;
                    end
                    else if (rem_reg[17])
                        done = 1'b1;
                    else
                    begin
                        wait_val = 8'd1;
                        use_cons = 1'b1;
                    end
                end
                PH_WAIT_ON:
                begin
                    if (item.meas_enabled)
                    begin
                        capture    = 1'b1;
                        wait_val   = item_wait;
                        phase_next = PH_STABLE1;
                        use_cons   = 1'b1;
                    end
                    else if (rem_reg[17])
                        done = 1'b1;
                    else
                    begin
                        wait_val = 8'd1;
                        use_cons = 1'b1;
                    end
                end
                PH_STABLE1, PH_STABLE2, PH_STABLE3:
                begin
                    if (!match)
                        done = 1'b1;
                    else if (phase_reg == PH_STABLE3)
                    begin
                        done = 1'b1;
                        ok   = 1'b1;
                    end
                    else
                    begin
                        wait_val   = item_wait;
                        phase_next = phase_reg + 3'd1;
                        use_cons   = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // A finished sequence drops the command and the wait.
        if (done)
        begin
            cmd        = CMD_NONE;
            wait_val   = 8'd0;
            phase_next = PH_IDLE;
        end
    end

    // Budget update, saturating at the floor.
    assign rem_base = is_start ? $signed({2'b00, item.timeout_ms}) : rem_reg;
    assign rem_diff = {rem_base[17], rem_base} - $signed({11'd0, wait_val});
    assign rem_cons = (rem_diff[18] && !rem_diff[17]) ? REM_MIN : rem_diff[17:0];
    assign rem_next = use_cons ? rem_cons : rem_reg;

    assign res.command  = cmd;
    assign res.wait_ms  = wait_val;
    assign res.done_res = done;
    assign res.success  = done && ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rem_reg    <= '0;
            ref_il_reg <= 1'b0;
            ref_vs_reg <= '0;
            ref_fl_reg <= '0;
            ref_bs_reg <= '0;
            ref_fc_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            if (capture)
            begin
                ref_il_reg <= item.meas_interlaced;
                ref_vs_reg <= item.vsync_lines;
                ref_fl_reg <= item.field_lines;
                ref_bs_reg <= item.block_size;
                ref_fc_reg <= item.field_cycles;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> phase_reg == PH_IDLE)
        else $error("phase not idle after finished sequence");

    a_start_to_wait_off: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_START |=> phase_reg == PH_WAIT_OFF)
        else $error("start did not enter wait-for-off");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cmd == CMD_NONE && wait_val == 8'd0)
        else $error("finished result carries a command or wait");

    a_idle_holds_budget: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_SAMPLE && phase_reg == PH_IDLE
        |=> $stable(rem_reg) && phase_reg == PH_IDLE)
        else $error("sample while idle changed state");
`endif

endmodule

// File: src/sync_timing_stability_checker.sv
`timescale 1ns / 1ps

// Sync-timing stability checker.
// Input stream (s_*): one word per item. s_tuser selects the kind: 0 starts a new
// check with the timeout budget in s_tdata, 1 delivers a status sample of the
// sync measurement. Every accepted word yields exactly one result word.
// Output stream (m_*): the command for the measurement unit (stop / start),
// the wait in ms before the next sample, and a success flag; m_tlast marks the
// word that finishes a check, success then tells stable timing from failure.
// Configuration (cfg_*): index 0 margin_per_line, index 1 restart_wait_ms;
// always ready, write only while no word is in flight.
// Path: an accepted word goes through the input register, then the sequencer
// logic into the result register, which drives m_tvalid. Throughput: one word
// per cycle while m_tready stays high; the sequencer state is updated in the
// same cycle the result is registered, so the next word sees it.
// Reset: config returns to margin 10 / restart wait 80, the sequencer to idle
// with a zero budget and a cleared reference; both registers are empty.
// Stall: when m_tready is low the result holds, the input register fills and
// then s_tready drops until the result is taken.

module sync_timing_stability_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] timeout_ms, [16] meas_enabled, [17] meas_interlaced,
    // [22:18] vsync_lines, [33:23] field_lines, [47:34] block_size,
    // [60:48] field_cycles, [63:61] zero
    input  logic [63:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] command, [9:2] wait_ms, [10] success, [15:11] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import stc_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  fire;

    // Advance the input word whenever the result register is free or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    stc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.operation       <= s_tuser;
            in_item_reg.timeout_ms      <= s_tdata[15:0];
            in_item_reg.meas_enabled    <= s_tdata[16];
            in_item_reg.meas_interlaced <= s_tdata[17];
            in_item_reg.vsync_lines     <= s_tdata[22:18];
            in_item_reg.field_lines     <= s_tdata[33:23];
            in_item_reg.block_size      <= s_tdata[47:34];
            in_item_reg.field_cycles    <= s_tdata[60:48];
        end
    end

    stc_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Result register: load on fire, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.success, out_res_reg.wait_ms, out_res_reg.command};
    assign m_tlast  = out_res_reg.done_res;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !fire)
        else $error("result overwritten while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("input word lost before processing");

    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word produced no result");
`endif

endmodule

// File: tb/stc_sequence_checker.sv
`timescale 1ns / 1ps

module stc_sequence_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        drained,
    output int          fail_count
);
    import stc_pkg::*;

    localparam int BUDGET_FLOOR = -131072;

    logic [7:0] margin;
    logic [7:0] restart_ms;
    logic [2:0] phase;
    int         budget_ms;
    item_t      ref_rd;
    res_t       due_results[$];

    function automatic logic [7:0] settle_wait(logic [12:0] cycles);
        int q;
        q = (int'(cycles) * 5000) / 223720;
        return q[7:0];
    endfunction

    function automatic void charge(logic [7:0] ms);
        budget_ms = budget_ms - int'(ms);
        if (budget_ms < BUDGET_FLOOR)
            budget_ms = BUDGET_FLOOR;
    endfunction

    function automatic bit reading_matches(item_t it);
        int fc_tol;
        int fc_diff;
        int bs_diff;
        fc_tol = (int'(ref_rd.field_lines) * int'(margin)) / 256;
        fc_diff = int'(ref_rd.field_cycles) - int'(it.field_cycles);
        bs_diff = int'(ref_rd.block_size) - int'(it.block_size);
        if (fc_diff < 0)
            fc_diff = -fc_diff;
        if (bs_diff < 0)
            bs_diff = -bs_diff;
        return it.meas_enabled && it.meas_interlaced == ref_rd.meas_interlaced &&
               it.vsync_lines == ref_rd.vsync_lines &&
               it.field_lines == ref_rd.field_lines &&
               fc_diff <= fc_tol && bs_diff <= int'(margin) * 8;
    endfunction

    // Advance the sequence by one word and return the result it produces.
    function automatic res_t step_sequence(item_t it);
        res_t r;
        bit   fin;
        r = '0;
        fin = 1'b0;
        if (it.operation == OP_START)
        begin
            budget_ms = int'(it.timeout_ms);
            r.command = CMD_STOP;
            r.wait_ms = 8'd1;
            phase = PH_WAIT_OFF;
            charge(r.wait_ms);
        end
        else
        begin
            case (phase) inside
                PH_WAIT_OFF:
                begin
                    if (!it.meas_enabled)
                    begin
                        r.command = CMD_START;
                        r.wait_ms = restart_ms;
                        phase = PH_WAIT_ON;
                        charge(r.wait_ms);
                    end
                    else if (budget_ms < 0)
                        fin = 1'b1;
                    else
                    begin
                        r.wait_ms = 8'd1;
                        charge(r.wait_ms);
                    end
                end
                PH_WAIT_ON:
                begin
                    if (it.meas_enabled)
                    begin
                        ref_rd = it;
                        r.wait_ms = settle_wait(it.field_cycles);
                        phase = PH_STABLE1;
                        charge(r.wait_ms);
                    end
                    else if (budget_ms < 0)
                        fin = 1'b1;
                    else
                    begin
                        r.wait_ms = 8'd1;
                        charge(r.wait_ms);
                    end
                end
                PH_STABLE1, PH_STABLE2, PH_STABLE3:
                begin
                    if (!reading_matches(it))
                        fin = 1'b1;
                    else if (phase == PH_STABLE3)
                    begin
                        fin = 1'b1;
                        r.success = 1'b1;
                    end
                    else
                    begin
                        r.wait_ms = settle_wait(it.field_cycles);
                        phase = phase + 3'd1;
                        charge(r.wait_ms);
                    end
                end
                default: ;
            endcase
        end
        if (fin)
        begin
            r.command = CMD_NONE;
            r.wait_ms = 8'd0;
            r.done_res = 1'b1;
            phase = PH_IDLE;
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        res_t  want;
        res_t  got;
        if (!rst_n)
        begin
            margin = MARGIN_RESET;
            restart_ms = RESTART_RESET;
            phase = PH_IDLE;
            budget_ms = 0;
            ref_rd = '0;
            due_results.delete();
            fail_count = 0;
            drained <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MARGIN)
                    margin = cfg_data;
                else
                    restart_ms = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got.command = m_tdata[1:0];
                got.wait_ms = m_tdata[9:2];
                got.success = m_tdata[10];
                got.done_res = m_tlast;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word %h with none expected, actual last=%0b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("command", want.command, got.command);
                    check_field("wait_ms", want.wait_ms, got.wait_ms);
                    check_field("done", want.done_res, got.done_res);
                    check_field("success", want.success, got.success);
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.operation = s_tuser;
                it.timeout_ms = s_tdata[15:0];
                it.meas_enabled = s_tdata[16];
                it.meas_interlaced = s_tdata[17];
                it.vsync_lines = s_tdata[22:18];
                it.field_lines = s_tdata[33:23];
                it.block_size = s_tdata[47:34];
                it.field_cycles = s_tdata[60:48];
                due_results.push_back(step_sequence(it));
            end
            drained <= (due_results.size() == 0);
        end
    end

endmodule

// File: tb/sync_timing_stability_checker_tb.sv
`timescale 1ns / 1ps

module sync_timing_stability_checker_tb;
    import stc_pkg::*;

    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        drained;
    int          fail_count;

    // Margin currently programmed; the stimulus needs it to aim at the
    // tolerance edges of the stable checks.
    logic [7:0]  cur_margin = MARGIN_RESET;
    bit          quiet = 1'b0;
    bit          gap_mode = 1'b1;
    bit          jam_mode = 1'b1;
    int          hold_left = 0;
    int          idle_cycles = 0;

    sync_timing_stability_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    stc_sequence_checker chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .drained   (drained),
        .fail_count(fail_count)
    );

    always #4 clk = ~clk;

    // Result side back-pressure: random stall bursts while jam_mode is on,
    // clean stretches while it is off, none once quiet.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (jam_mode && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            hold_left <= $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
        if ($urandom_range(0, 63) == 0)
            jam_mode <= !jam_mode;
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sample word layout, lowest bits first: timeout, enable, interlace,
    // vsync lines, field lines, block size, field cycles.
    function automatic logic [63:0] pack_item(logic [15:0] tmo, logic en, logic il,
                                              logic [4:0] vs, logic [10:0] fl,
                                              logic [13:0] bs, logic [12:0] fc);
        return {3'b000, fc, bs, fl, vs, il, en, tmo};
    endfunction

    function automatic logic [63:0] random_word();
        return {3'b000, 29'($urandom), $urandom};
    endfunction

    // Build a reading that repeats the reference, either inside every
    // tolerance (leaning on the edges) or broken in exactly one way.
    function automatic logic [63:0] stable_reading(logic [63:0] refw, bit good);
        logic [63:0] w;
        int          fc_tol;
        int          bs_tol;
        int          fc;
        int          bs;
        int          ref_fc;
        int          ref_bs;
        w = random_word();
        w[60:17] = refw[60:17];
        w[16] = 1'b1;
        ref_fc = int'(refw[60:48]);
        ref_bs = int'(refw[47:34]);
        fc_tol = (int'(refw[33:23]) * int'(cur_margin)) / 256;
        bs_tol = int'(cur_margin) * 8;
        if (good)
        begin
            case ($urandom_range(0, 3))
                0: fc = ref_fc - fc_tol;
                1: fc = ref_fc + fc_tol;
                default: fc = ref_fc + int'($urandom_range(0, 2 * fc_tol)) - fc_tol;
            endcase
            case ($urandom_range(0, 3))
                0: bs = ref_bs - bs_tol;
                1: bs = ref_bs + bs_tol;
                default: bs = ref_bs + int'($urandom_range(0, 2 * bs_tol)) - bs_tol;
            endcase
            // Clamping toward the reference keeps the reading inside tolerance.
            fc = (fc < 0) ? 0 : (fc > 8191) ? 8191 : fc;
            bs = (bs < 0) ? 0 : (bs > 16383) ? 16383 : bs;
            w[60:48] = 13'(fc);
            w[47:34] = 14'(bs);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: w[16] = 1'b0;
                1: w[17] = ~w[17];
                2: w[22:18] = w[22:18] ^ 5'($urandom_range(1, 31));
                3: w[33:23] = w[33:23] ^ 11'($urandom_range(1, 2047));
                4:
                begin
                    if (ref_fc + fc_tol + 1 <= 8191)
                        w[60:48] = 13'(ref_fc + fc_tol + 1);
                    else if (ref_fc >= fc_tol + 1)
                        w[60:48] = 13'(ref_fc - fc_tol - 1);
                    else
                        w[17] = ~w[17];
                end
                default:
                begin
                    if (ref_bs + bs_tol + 1 <= 16383)
                        w[47:34] = 14'(ref_bs + bs_tol + 1);
                    else if (ref_bs >= bs_tol + 1)
                        w[47:34] = 14'(ref_bs - bs_tol - 1);
                    else
                        w[17] = ~w[17];
                end
            endcase
        end
        return w;
    endfunction

    // Present one word and hold it until the block takes it. An idle burst
    // may come first, unless the run is in its quiet tail.
    task automatic send_word(logic op, logic [63:0] data);
        if ($urandom_range(0, 31) == 0)
            gap_mode = !gap_mode;
        if (!quiet && gap_mode && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and hold off until every result in flight has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (!drained);
    endtask

    // Program both registers back to back; valid stays high between them.
    task automatic write_settings(logic [7:0] margin, logic [7:0] restart);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MARGIN;
        cfg_data <= margin;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_RESTART;
        cfg_data <= restart;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_margin = margin;
    endtask

    // One check from start to its end: readings that stay on, the drop,
    // readings still off, the reference and the three stable checks. A short
    // budget now and then steers it into the timeout branches, and a stray
    // start or a noise sample breaks the order from time to time.
    task automatic run_check();
        logic [63:0] w;
        logic [63:0] refw;
        bit          tight;
        int          n_on;
        int          n_off;
        tight = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 5) == 0)
            send_word(OP_SAMPLE, random_word());
        w = random_word();
        w[15:0] = tight ? 16'($urandom_range(0, 300)) : 16'($urandom_range(400, 65535));
        send_word(OP_START, w);
        n_on = tight ? $urandom_range(0, 12) : $urandom_range(0, 2);
        repeat (n_on)
        begin
            w = random_word();
            w[16] = 1'b1;
            send_word(OP_SAMPLE, w);
        end
        if ($urandom_range(0, 11) == 0)
        begin
            // Abandon the running check and begin again.
            w = random_word();
            w[15:0] = 16'($urandom_range(400, 65535));
            send_word(OP_START, w);
        end
        w = random_word();
        w[16] = 1'b0;
        send_word(OP_SAMPLE, w);
        n_off = tight ? $urandom_range(0, 6) : $urandom_range(0, 2);
        repeat (n_off)
        begin
            w = random_word();
            w[16] = 1'b0;
            send_word(OP_SAMPLE, w);
        end
        refw = random_word();
        refw[16] = 1'b1;
        send_word(OP_SAMPLE, refw);
        repeat (3)
            send_word(OP_SAMPLE, stable_reading(refw, $urandom_range(0, 9) != 0));
    endtask

    initial
    begin
        logic [7:0] margin;
        logic [7:0] restart;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: margin 10, restart wait 80.
        // Sample with no check running must come back empty.
        send_word(OP_SAMPLE, pack_item(16'hFFFF, 1'b1, 1'b1, 5'd31, 11'd2047,
                                       14'h3FFF, 13'h1FFF));
        // Zero budget: the stop costs 1 ms, so the next enabled sample times out.
        send_word(OP_START, pack_item(16'd0, 1'b1, 1'b1, 5'd31, 11'd2047,
                                      14'h3FFF, 13'h1FFF));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        // Full budget, all-ones reference, three exact repeats: stable.
        send_word(OP_START, pack_item(16'hFFFF, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        repeat (4)
            send_word(OP_SAMPLE, pack_item(16'h0, 1'b1, 1'b1, 5'd31, 11'd2047,
                                           14'h3FFF, 13'h1FFF));
        // All-zero reference; block size exactly at margin*8, then one past it.
        send_word(OP_START, pack_item(16'hFFFF, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd80, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd81, 13'd0));
        // Budget spent by the restart wait: timeout while waiting for a reading.
        send_word(OP_START, pack_item(16'd50, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        // Start while running, then field cycles at the upper tolerance edge and
        // one past the lower one (2047 lines at margin 10 give 79).
        send_word(OP_START, pack_item(16'd1000, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_START, pack_item(16'd300, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b0, 1'b0, 5'd0, 11'd0, 14'd0, 13'd0));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd9, 11'd2047, 14'd5000, 13'd1000));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd9, 11'd2047, 14'd5000, 13'd1079));
        send_word(OP_SAMPLE, pack_item(16'd0, 1'b1, 1'b0, 5'd9, 11'd2047, 14'd5000, 13'd920));

        // Random part: extreme settings first, then random ones; the last
        // phase runs without any idling on either side.
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: begin margin = 8'd0;   restart = 8'd0;   end
                1: begin margin = 8'd255; restart = 8'd255; end
                2: begin margin = 8'd0;   restart = 8'd255; end
                3: begin margin = 8'd255; restart = 8'd0;   end
                default:
                begin
                    margin = 8'($urandom_range(0, 255));
                    restart = 8'($urandom_range(0, 255));
                end
            endcase
            wait_drained();
            write_settings(margin, restart);
            quiet = (p == 6);
            repeat (24) run_check();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sync_timing_stability_checker.f
src/stc_pkg.sv
src/stc_cfg_regs.sv
src/stc_seq.sv
src/sync_timing_stability_checker.sv
tb/stc_sequence_checker.sv
tb/sync_timing_stability_checker_tb.sv
